>>> rtl/core/pvt_pkg.sv
// Shared types, constants and the Q1.14 sine function for the polygon
// vertex transform. No dependencies.
package pvt_pkg;

  localparam int MAX_VERTICES_DEF = 32;
  localparam int COORD_W          = 16;
  localparam int CFG_AW           = 3;
  localparam int CFG_DW           = 32;
  localparam int COUNT_W          = 6;

  // register indexes on the configuration port
  localparam logic REG_VERTEX_COUNT = 1'b0;

  typedef enum logic [1:0] {
    ACT_LOAD      = 2'd0,
    ACT_TRANSLATE = 2'd1,
    ACT_ROTATE    = 2'd2,
    ACT_SCALE     = 2'd3
  } act_t;

  typedef struct packed {
    act_t               action;
    logic [4:0]         vertex_index;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic [8:0]         angle_deg;
    logic signed [15:0] scale_x;
    logic signed [15:0] scale_y;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] edge_x0;
    logic signed [15:0] edge_y0;
    logic signed [15:0] edge_x1;
    logic signed [15:0] edge_y1;
    logic               edge_last;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_TRIG, ST_READ, ST_DIFF, ST_MUL, ST_ACC, ST_FIN, ST_WRITE, ST_EMIT
  } state_t;

  // round(16384 * sin(d degrees)), d = 0..90
  function automatic logic [14:0] sin_quarter(input logic [6:0] d);
    logic [14:0] v;
    unique case (d)
      7'd0: v = 15'd0;      7'd1: v = 15'd286;    7'd2: v = 15'd572;
      7'd3: v = 15'd857;    7'd4: v = 15'd1143;   7'd5: v = 15'd1428;
      7'd6: v = 15'd1713;   7'd7: v = 15'd1997;   7'd8: v = 15'd2280;
      7'd9: v = 15'd2563;   7'd10: v = 15'd2845;  7'd11: v = 15'd3126;
      7'd12: v = 15'd3406;  7'd13: v = 15'd3686;  7'd14: v = 15'd3964;
      7'd15: v = 15'd4240;  7'd16: v = 15'd4516;  7'd17: v = 15'd4790;
      7'd18: v = 15'd5063;  7'd19: v = 15'd5334;  7'd20: v = 15'd5604;
      7'd21: v = 15'd5872;  7'd22: v = 15'd6138;  7'd23: v = 15'd6402;
      7'd24: v = 15'd6664;  7'd25: v = 15'd6924;  7'd26: v = 15'd7182;
      7'd27: v = 15'd7438;  7'd28: v = 15'd7692;  7'd29: v = 15'd7943;
      7'd30: v = 15'd8192;  7'd31: v = 15'd8438;  7'd32: v = 15'd8682;
      7'd33: v = 15'd8923;  7'd34: v = 15'd9162;  7'd35: v = 15'd9397;
      7'd36: v = 15'd9630;  7'd37: v = 15'd9860;  7'd38: v = 15'd10087;
      7'd39: v = 15'd10311; 7'd40: v = 15'd10531; 7'd41: v = 15'd10749;
      7'd42: v = 15'd10963; 7'd43: v = 15'd11174; 7'd44: v = 15'd11381;
      7'd45: v = 15'd11585; 7'd46: v = 15'd11786; 7'd47: v = 15'd11982;
      7'd48: v = 15'd12176; 7'd49: v = 15'd12365; 7'd50: v = 15'd12551;
      7'd51: v = 15'd12733; 7'd52: v = 15'd12911; 7'd53: v = 15'd13085;
      7'd54: v = 15'd13255; 7'd55: v = 15'd13421; 7'd56: v = 15'd13583;
      7'd57: v = 15'd13741; 7'd58: v = 15'd13894; 7'd59: v = 15'd14044;
      7'd60: v = 15'd14189; 7'd61: v = 15'd14330; 7'd62: v = 15'd14466;
      7'd63: v = 15'd14598; 7'd64: v = 15'd14726; 7'd65: v = 15'd14849;
      7'd66: v = 15'd14968; 7'd67: v = 15'd15082; 7'd68: v = 15'd15191;
      7'd69: v = 15'd15296; 7'd70: v = 15'd15396; 7'd71: v = 15'd15491;
      7'd72: v = 15'd15582; 7'd73: v = 15'd15668; 7'd74: v = 15'd15749;
      7'd75: v = 15'd15826; 7'd76: v = 15'd15897; 7'd77: v = 15'd15964;
      7'd78: v = 15'd16026; 7'd79: v = 15'd16083; 7'd80: v = 15'd16135;
      7'd81: v = 15'd16182; 7'd82: v = 15'd16225; 7'd83: v = 15'd16262;
      7'd84: v = 15'd16294; 7'd85: v = 15'd16322; 7'd86: v = 15'd16344;
      7'd87: v = 15'd16362; 7'd88: v = 15'd16374; 7'd89: v = 15'd16382;
      7'd90: v = 15'd16384;
      default: v = 15'd0;
    endcase
    return v;
  endfunction

  // sine of a whole-degree angle 0..359, signed Q1.14
  function automatic logic signed [15:0] sin_deg(input logic [8:0] a);
    logic [14:0] m;
    logic        neg;
    begin
      neg = 1'b0;
      if (a <= 9'd90) begin
        m = sin_quarter(7'(a));
      end else if (a <= 9'd180) begin
        m = sin_quarter(7'(9'd180 - a));
      end else if (a <= 9'd270) begin
        m = sin_quarter(7'(a - 9'd180));
        neg = 1'b1;
      end else begin
        m = sin_quarter(7'(9'd360 - a));
        neg = 1'b1;
      end
      return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
    end
  endfunction

endpackage

>>> rtl/core/polygon_vertex_transform.sv
// Polygon vertex transform top level: vertex store, sequencer, shared multiplier.
// Depends on pvt_pkg and pvt_ram.
//
// A load transfer writes one vertex to the store in the cycle it is accepted. A
// transform walks the vertices in use one at a time; rotate and scale share a
// single 17x16 multiplier, after a sine/cosine lookup at the start. The edge
// ending at each vertex after vertex 0 is held in the output register until it
// is taken, and no input is accepted until the closing edge back to vertex 0
// has been transferred. The multiplier and the one read port of the vertex RAM
// are why the vertices go one at a time.
module polygon_vertex_transform
  #(
  parameter int MAX_VERTICES = pvt_pkg::MAX_VERTICES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  pvt_pkg::in_item_t            in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output pvt_pkg::out_item_t           out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pvt_pkg::CFG_AW-1:0]   paddr,
  input  logic [pvt_pkg::CFG_DW-1:0]   pwdata,
  output logic [pvt_pkg::CFG_DW-1:0]   prdata,
  output logic                         pready
);
  import pvt_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int AB = 7;

  state_t state_r, state_nxt;

  logic [COUNT_W-1:0]  count_r;
  in_item_t            item_r;
  logic [CW-1:0]       n_r;
  logic [AW-1:0]       i_r;
  logic                half_r;
  logic [1:0]          k_r;
  logic signed [15:0]  sin_r, cos_r;
  logic signed [16:0]  dx_r, dy_r;
  logic signed [32:0]  prod_r;
  logic signed [33:0]  acc_r;
  logic signed [15:0]  new_x_r, new_y_r;
  logic signed [15:0]  prev_x_r, prev_y_r, v0_x_r, v0_y_r;
  out_item_t           out_r;

  // config port
  logic cfg_wr;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_VERTEX_COUNT) ? CFG_DW'(count_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cfg_wr && paddr[2] == REG_VERTEX_COUNT) begin
      count_r <= pwdata[COUNT_W-1:0];
    end
  end

  // count in use, clipped to the store
  logic [AB-1:0] count_ext, idx_ext;
  logic [CW-1:0] n_in;
  logic          load_ok, in_xfer, is_load;
  assign count_ext = AB'(count_r);
  assign idx_ext   = AB'(in_data.vertex_index);
  assign n_in      = (count_ext >= AB'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : CW'(count_r);
  assign load_ok   = idx_ext < AB'(MAX_VERTICES);
  assign in_xfer   = in_valid & in_ready;
  assign is_load   = in_data.action == ACT_LOAD;

  // angle reduction and cosine argument
  logic [8:0] ang_red, cos_arg;
  assign ang_red = (item_r.angle_deg >= 9'd360) ? item_r.angle_deg - 9'd360
                                                 : item_r.angle_deg;
  assign cos_arg = (ang_red <= 9'd90) ? 9'd90 - ang_red : 9'd450 - ang_red;

  // vertex RAM
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata, ram_rdata;

  pvt_ram #(.WIDTH(32), .DEPTH(MAX_VERTICES)) u_ram (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_en  (ram_re),
    .rd_addr(i_r),
    .rd_data(ram_rdata)
  );

  logic signed [15:0] cur_x, cur_y;
  assign cur_x = $signed(ram_rdata[31:16]);
  assign cur_y = $signed(ram_rdata[15:0]);

  logic is_rot, is_trans, fin_now, last_vtx, first_only;
  assign is_rot     = item_r.action == ACT_ROTATE;
  assign is_trans   = item_r.action == ACT_TRANSLATE;
  assign fin_now    = !is_rot || k_r[0];
  assign last_vtx   = (CW'(i_r) + CW'(1)) == n_r;
  assign first_only = (i_r == '0) && (n_r != CW'(1));

  // shared multiplier operands
  logic signed [16:0] op_a;
  logic signed [15:0] op_b;
  always_comb begin
    op_a = k_r[0] ? dy_r : dx_r;
    if (is_rot) begin
      op_b = (k_r == 2'd0 || k_r == 2'd3) ? cos_r : sin_r;
    end else begin
      op_b = k_r[0] ? item_r.scale_y : item_r.scale_x;
    end
  end

  // round half away from zero, add center, saturate
  logic [33:0]        mag;
  logic [34:0]        mag_h;
  logic [22:0]        q;
  logic signed [23:0] rval, val;
  logic signed [24:0] sum;
  logic signed [15:0] fin_val;
  always_comb begin
    mag   = acc_r[33] ? 34'(-acc_r) : 34'(acc_r);
    mag_h = {1'b0, mag} + (is_rot ? 35'd8192 : 35'd2048);
    q     = is_rot ? 23'(mag_h >> 14) : 23'(mag_h >> 12);
    rval  = acc_r[33] ? -$signed({1'b0, q}) : $signed({1'b0, q});
    if (is_trans) begin
      val = half_r ? 24'(cur_y) : 24'(cur_x);
    end else begin
      val = rval;
    end
    sum = 25'(half_r ? item_r.coord_y : item_r.coord_x) + 25'(val);
    if (sum > 25'sd32767) begin
      fin_val = 16'sh7fff;
    end else if (sum < -25'sd32768) begin
      fin_val = -16'sh8000;
    end else begin
      fin_val = 16'(sum);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_xfer && !is_load && n_in != '0) state_nxt = ST_TRIG;
      ST_TRIG:  state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_DIFF;
      ST_DIFF:  state_nxt = is_trans ? ST_FIN : ST_MUL;
      ST_MUL:   state_nxt = ST_ACC;
      ST_ACC:   state_nxt = fin_now ? ST_FIN : ST_MUL;
      ST_FIN: begin
        if (half_r) state_nxt = ST_WRITE;
        else        state_nxt = is_trans ? ST_FIN : ST_MUL;
      end
      ST_WRITE: state_nxt = first_only ? ST_READ : ST_EMIT;
      ST_EMIT: begin
        if (out_ready) begin
          if (out_r.edge_last) state_nxt = ST_IDLE;
          else if (!last_vtx)  state_nxt = ST_READ;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready  = state_r == ST_IDLE;
    out_valid = state_r == ST_EMIT;
    ram_re    = state_r == ST_READ;
    ram_we    = (in_xfer && is_load && load_ok) || state_r == ST_WRITE;
    ram_waddr = (state_r == ST_WRITE) ? i_r : idx_ext[AW-1:0];
    ram_wdata = (state_r == ST_WRITE) ? {new_x_r, new_y_r}
                                      : {in_data.coord_x, in_data.coord_y};
  end
  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          item_r <= in_data;
          n_r    <= n_in;
          i_r    <= '0;
        end
      end
      ST_TRIG: begin
        sin_r <= sin_deg(ang_red);
        cos_r <= sin_deg(cos_arg);
      end
      ST_DIFF: begin
        dx_r   <= 17'(cur_x) - 17'(item_r.coord_x);
        dy_r   <= 17'(cur_y) - 17'(item_r.coord_y);
        half_r <= 1'b0;
        k_r    <= '0;
      end
      ST_MUL: prod_r <= op_a * op_b;
      ST_ACC: begin
        if (!is_rot || !k_r[0]) acc_r <= 34'(prod_r);
        else if (k_r[1])        acc_r <= acc_r + 34'(prod_r);
        else                    acc_r <= acc_r - 34'(prod_r);
        k_r <= k_r + 2'd1;
      end
      ST_FIN: begin
        if (half_r) new_y_r <= fin_val;
        else        new_x_r <= fin_val;
        half_r <= 1'b1;
      end
      ST_WRITE: begin
        prev_x_r <= new_x_r;
        prev_y_r <= new_y_r;
        if (i_r == '0) begin
          v0_x_r <= new_x_r;
          v0_y_r <= new_y_r;
        end
        if (first_only) begin
          i_r <= i_r + AW'(1);
        end
        out_r.edge_x0   <= (i_r == '0) ? new_x_r : prev_x_r;
        out_r.edge_y0   <= (i_r == '0) ? new_y_r : prev_y_r;
        out_r.edge_x1   <= new_x_r;
        out_r.edge_y1   <= new_y_r;
        out_r.edge_last <= n_r == CW'(1);
      end
      ST_EMIT: begin
        if (out_ready && !out_r.edge_last) begin
          if (last_vtx) begin
            // closing edge back to vertex 0
            out_r.edge_x0   <= prev_x_r;
            out_r.edge_y0   <= prev_y_r;
            out_r.edge_x1   <= v0_x_r;
            out_r.edge_y1   <= v0_y_r;
            out_r.edge_last <= 1'b1;
          end else begin
            i_r <= i_r + AW'(1);
          end
        end
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/core/pvt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pvt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

>>> rtl/core/pvt_checker.sv
// Port-level checks for polygon_vertex_transform, bound to the top level.
// Depends on pvt_pkg.
module pvt_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input pvt_pkg::in_item_t          in_data,
  input logic                       out_valid,
  input logic                       out_ready,
  input pvt_pkg::out_item_t         out_data,
  input logic [pvt_pkg::CFG_AW-1:0] paddr,
  input logic [pvt_pkg::CFG_DW-1:0] prdata
);
  import pvt_pkg::*;

  // a held edge keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("edge payload changed while stalled");

  // no intake while an edge is pending
  a_busy_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while an edge waits");

  // a transform over a nonempty polygon makes the block busy
  a_busy_xform: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.action != ACT_LOAD &&
    paddr[2] == REG_VERTEX_COUNT && prdata != '0 |=> !in_ready)
    else $error("transform transfer did not start work");

  // after a load the block is ready again in the next cycle, with no edge pending
  a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.action == ACT_LOAD |=> in_ready && !out_valid)
    else $error("load did not return to idle");

endmodule

bind polygon_vertex_transform pvt_checker u_pvt_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data),
  .paddr    (paddr),
  .prdata   (prdata)
);
